// ===== sv/dlp_pkg.sv =====
package dlp_pkg;

    localparam int NODE_W   = 6;
    localparam int WEIGHT_W = 16;
    localparam int CFG_W    = 7;
    localparam int DIST_W   = 23;
    localparam int PATH_W   = 22;
    localparam int EDGE_W   = 2 * NODE_W + WEIGHT_W;

    localparam logic [CFG_W-1:0]  CFG_RESET = 7'd64;
    localparam logic [DIST_W-1:0] PATH_MAX  = 23'sd2097151;
    localparam logic [DIST_W-1:0] PATH_MIN  = -23'sd2097152;

    typedef enum logic [4:0] {
        S_IDLE, S_CLR, S_DEG_RD, S_DEG_CK, S_DEG_WR, S_SEED_RD, S_SEED_CK,
        S_HEAD, S_U, S_K_RD, S_K_CK, S_K_WR, S_ROOT_RD, S_ROOT, S_T_RD,
        S_T_CK, S_DU, S_R_RD, S_R_CK, S_R_WR, S_LAST_RD, S_LAST, S_OUT, S_FAIL
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_START, OP_CLR, OP_EDGE_RD, OP_EDGE_NEXT,
        OP_DEG_RD, OP_DEG_INC, OP_SEED_RD, OP_SEED_CK, OP_HEAD_RD,
        OP_U_LATCH, OP_DEG_DEC, OP_ROOT_RD, OP_ROOT_SET, OP_TOPO_RD,
        OP_U_BEST, OP_DU_LATCH, OP_BEST_RD, OP_RELAX, OP_LAST_RD,
        OP_LAST_BEST, OP_OUT, OP_FAIL_OUT
    } t_op;

    typedef struct packed {
        logic in_valid;
        logic in_mode;
        logic idx_last;
        logic edge_done;
        logic live;
        logic hit;
        logic head_lt_tail;
        logic tail_zero;
        logic topo_done;
        logic reached_t;
        logic out_free;
    } t_stat;

endpackage

// ===== sv/dlp_in_if.sv =====
interface dlp_in_if;
    logic                        valid;
    logic                        ready;
    logic                        mode;
    logic [dlp_pkg::NODE_W-1:0]  src_node;
    logic [dlp_pkg::NODE_W-1:0]  dst_node;
    logic signed [dlp_pkg::WEIGHT_W-1:0] edge_weight;

    modport source (output valid, mode, src_node, dst_node, edge_weight, input ready);
    modport sink (input valid, mode, src_node, dst_node, edge_weight, output ready);
endinterface

// ===== sv/dlp_out_if.sv =====
interface dlp_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [dlp_pkg::PATH_W-1:0] path_length;
    logic                              unreachable;
    logic                              cycle_found;

    modport source (output valid, path_length, unreachable, cycle_found, input ready);
    modport sink (input valid, path_length, unreachable, cycle_found, output ready);
endinterface

// ===== sv/dlp_ram.sv =====
module dlp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

// ===== sv/dlp_ctrl.sv =====
module dlp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  dlp_pkg::t_stat i_stat,
    output dlp_pkg::t_op   o_op,
    output logic           o_in_ready
);
    import dlp_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_op       = OP_NONE;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    if (i_stat.in_mode) begin
                        o_op    = OP_START;
                        n_state = S_CLR;
                    end else begin
                        o_op = OP_LOAD;
                    end
                end
            end
            S_CLR: begin
                o_op = OP_CLR;
                if (i_stat.idx_last) n_state = S_DEG_RD;
            end
            S_DEG_RD: begin
                if (i_stat.edge_done) begin
                    n_state = S_SEED_RD;
                end else begin
                    o_op    = OP_EDGE_RD;
                    n_state = S_DEG_CK;
                end
            end
            S_DEG_CK: begin
                if (i_stat.live) begin
                    o_op    = OP_DEG_RD;
                    n_state = S_DEG_WR;
                end else begin
                    o_op    = OP_EDGE_NEXT;
                    n_state = S_DEG_RD;
                end
            end
            S_DEG_WR: begin
                o_op    = OP_DEG_INC;
                n_state = S_DEG_RD;
            end
            S_SEED_RD: begin
                o_op    = OP_SEED_RD;
                n_state = S_SEED_CK;
            end
            S_SEED_CK: begin
                o_op    = OP_SEED_CK;
                n_state = i_stat.idx_last ? S_HEAD : S_SEED_RD;
            end
            S_HEAD: begin
                if (i_stat.head_lt_tail) begin
                    o_op    = OP_HEAD_RD;
                    n_state = S_U;
                end else begin
                    n_state = i_stat.tail_zero ? S_FAIL : S_ROOT_RD;
                end
            end
            S_U: begin
                o_op    = OP_U_LATCH;
                n_state = S_K_RD;
            end
            S_K_RD: begin
                if (i_stat.edge_done) begin
                    n_state = S_HEAD;
                end else begin
                    o_op    = OP_EDGE_RD;
                    n_state = S_K_CK;
                end
            end
            S_K_CK: begin
                if (i_stat.hit) begin
                    o_op    = OP_DEG_RD;
                    n_state = S_K_WR;
                end else begin
                    o_op    = OP_EDGE_NEXT;
                    n_state = S_K_RD;
                end
            end
            S_K_WR: begin
                o_op    = OP_DEG_DEC;
                n_state = S_K_RD;
            end
            S_ROOT_RD: begin
                o_op    = OP_ROOT_RD;
                n_state = S_ROOT;
            end
            S_ROOT: begin
                o_op    = OP_ROOT_SET;
                n_state = S_T_RD;
            end
            S_T_RD: begin
                if (i_stat.topo_done) begin
                    n_state = S_LAST_RD;
                end else begin
                    o_op    = OP_TOPO_RD;
                    n_state = S_T_CK;
                end
            end
            S_T_CK: begin
                // Nodes that were never reached are not relaxed from.
                if (i_stat.reached_t) begin
                    o_op    = OP_U_BEST;
                    n_state = S_DU;
                end else begin
                    n_state = S_T_RD;
                end
            end
            S_DU: begin
                o_op    = OP_DU_LATCH;
                n_state = S_R_RD;
            end
            S_R_RD: begin
                if (i_stat.edge_done) begin
                    n_state = S_T_RD;
                end else begin
                    o_op    = OP_EDGE_RD;
                    n_state = S_R_CK;
                end
            end
            S_R_CK: begin
                if (i_stat.hit) begin
                    o_op    = OP_BEST_RD;
                    n_state = S_R_WR;
                end else begin
                    o_op    = OP_EDGE_NEXT;
                    n_state = S_R_RD;
                end
            end
            S_R_WR: begin
                o_op    = OP_RELAX;
                n_state = S_R_RD;
            end
            S_LAST_RD: begin
                o_op    = OP_LAST_RD;
                n_state = S_LAST;
            end
            S_LAST: begin
                o_op    = OP_LAST_BEST;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    o_op    = OP_OUT;
                    n_state = S_IDLE;
                end
            end
            S_FAIL: begin
                if (i_stat.out_free) begin
                    o_op    = OP_FAIL_OUT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE)
        else $error("input ready outside idle");
    a_start_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_op == OP_START |=> r_state == S_CLR)
        else $error("compute did not start with clearing");
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_op == OP_OUT || o_op == OP_FAIL_OUT) |-> i_stat.out_free)
        else $error("result loaded into a busy output register");
`endif
endmodule

// ===== sv/dlp_dpath.sv =====
module dlp_dpath #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [dlp_pkg::CFG_W-1:0]            i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_mode,
    input  logic [dlp_pkg::NODE_W-1:0]           i_src_node,
    input  logic [dlp_pkg::NODE_W-1:0]           i_dst_node,
    input  logic signed [dlp_pkg::WEIGHT_W-1:0]  i_edge_weight,
    input  dlp_pkg::t_op                         i_op,
    output dlp_pkg::t_stat                       o_stat,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output logic signed [dlp_pkg::PATH_W-1:0]    o_path_length,
    output logic                                 o_unreachable,
    output logic                                 o_cycle_found
);
    import dlp_pkg::*;

    localparam int NW   = $clog2(MAX_NODES);
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int EIW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNTW = $clog2(MAX_EDGES + 1);
    localparam int SEXT = DIST_W - WEIGHT_W;

    logic [CFG_W-1:0]  r_node_count;
    logic [CW-1:0]     n_eff;
    logic [CNTW-1:0]   r_cnt;
    logic [CNTW-1:0]   r_eidx;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_head;
    logic [CW-1:0]     r_tail;
    logic [NW-1:0]     r_u;
    logic [DIST_W-1:0] r_du;
    logic              r_last_reached;
    logic [MAX_NODES-1:0] r_reached;
    logic              r_ovalid;
    logic signed [PATH_W-1:0] r_path;
    logic              r_unreach;
    logic              r_cycle;

    logic [EDGE_W-1:0] edge_q;
    logic [NODE_W-1:0] e_src, e_dst;
    logic [WEIGHT_W-1:0] e_w;
    logic [NW-1:0]     e_dst_n;
    logic [CNTW-1:0]   deg_q;
    logic [NW-1:0]     topo_q;
    logic [DIST_W-1:0] best_q;
    logic [DIST_W-1:0] cand;
    logic [CNTW-1:0]   deg_dec;
    logic              live, hit, idx_last, out_free, load_ok;

    logic              deg_we, deg_re, topo_we, topo_re, best_we, best_re;
    logic [NW-1:0]     deg_wa, deg_ra, topo_wa, topo_ra, best_wa, best_ra;
    logic [CNTW-1:0]   deg_wd;
    logic [NW-1:0]     topo_wd;
    logic [DIST_W-1:0] best_wd;
    logic [DIST_W-1:0] path_sat;

    always_comb begin
        if (r_node_count == '0) begin
            n_eff = CW'(1);
        end else if (32'(r_node_count) > MAX_NODES) begin
            n_eff = CW'(MAX_NODES);
        end else begin
            n_eff = CW'(r_node_count);
        end
    end

    assign {e_src, e_dst, e_w} = edge_q;
    assign e_dst_n  = NW'(e_dst);
    assign live     = (32'(e_src) < 32'(n_eff)) && (32'(e_dst) < 32'(n_eff));
    assign hit      = live && (NW'(e_src) == r_u);
    assign idx_last = (32'(r_idx) + 32'd1) == 32'(n_eff);
    assign out_free = !r_ovalid || i_out_ready;
    assign load_ok  = (32'(i_src_node) < 32'(n_eff)) && (32'(i_dst_node) < 32'(n_eff))
                      && (32'(r_cnt) < MAX_EDGES);
    assign cand     = r_du + {{SEXT{e_w[WEIGHT_W-1]}}, e_w};
    assign deg_dec  = deg_q - CNTW'(1);

    assign o_stat.in_valid     = i_in_valid;
    assign o_stat.in_mode      = i_in_mode;
    assign o_stat.idx_last     = idx_last;
    assign o_stat.edge_done    = r_eidx == r_cnt;
    assign o_stat.live         = live;
    assign o_stat.hit          = hit;
    assign o_stat.head_lt_tail = r_head < r_tail;
    assign o_stat.tail_zero    = r_tail == '0;
    assign o_stat.topo_done    = r_idx == r_tail;
    assign o_stat.reached_t    = r_reached[topo_q];
    assign o_stat.out_free     = out_free;

    // Node store port steering.
    always_comb begin
        deg_we  = 1'b0;
        deg_wa  = NW'(r_idx);
        deg_wd  = '0;
        deg_re  = 1'b0;
        deg_ra  = e_dst_n;
        topo_we = 1'b0;
        topo_wa = NW'(r_tail);
        topo_wd = NW'(r_idx);
        topo_re = 1'b0;
        topo_ra = NW'(r_head);
        best_we = 1'b0;
        best_wa = e_dst_n;
        best_wd = cand;
        best_re = 1'b0;
        best_ra = e_dst_n;
        case (i_op)
            OP_CLR:     deg_we = 1'b1;
            OP_DEG_RD:  deg_re = 1'b1;
            OP_DEG_INC: begin
                deg_we = 1'b1;
                deg_wa = e_dst_n;
                deg_wd = deg_q + CNTW'(1);
            end
            OP_SEED_RD: begin
                deg_re = 1'b1;
                deg_ra = NW'(r_idx);
            end
            OP_SEED_CK: topo_we = deg_q == '0;
            OP_DEG_DEC: begin
                deg_we  = 1'b1;
                deg_wa  = e_dst_n;
                deg_wd  = deg_dec;
                topo_we = (deg_dec == '0) && (r_tail < n_eff);
                topo_wd = e_dst_n;
            end
            OP_HEAD_RD: topo_re = 1'b1;
            OP_ROOT_RD: begin
                topo_re = 1'b1;
                topo_ra = '0;
            end
            OP_TOPO_RD: begin
                topo_re = 1'b1;
                topo_ra = NW'(r_idx);
            end
            OP_LAST_RD: begin
                topo_re = 1'b1;
                topo_ra = NW'(r_tail - CW'(1));
            end
            OP_ROOT_SET: begin
                best_we = 1'b1;
                best_wa = topo_q;
                best_wd = '0;
            end
            OP_U_BEST, OP_LAST_BEST: begin
                best_re = 1'b1;
                best_ra = topo_q;
            end
            OP_BEST_RD: best_re = 1'b1;
            OP_RELAX: best_we = !r_reached[e_dst_n] || ($signed(cand) > $signed(best_q));
            default: ;
        endcase
    end

    dlp_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (i_op == OP_LOAD && load_ok),
        .i_waddr (r_cnt[EIW-1:0]),
        .i_wdata ({i_src_node, i_dst_node, i_edge_weight}),
        .i_re    (i_op == OP_EDGE_RD),
        .i_raddr (r_eidx[EIW-1:0]),
        .o_rdata (edge_q)
    );

    dlp_ram #(.WIDTH(CNTW), .DEPTH(MAX_NODES)) u_deg_ram (
        .i_clk (i_clk), .i_we (deg_we), .i_waddr (deg_wa), .i_wdata (deg_wd),
        .i_re (deg_re), .i_raddr (deg_ra), .o_rdata (deg_q)
    );

    dlp_ram #(.WIDTH(NW), .DEPTH(MAX_NODES)) u_topo_ram (
        .i_clk (i_clk), .i_we (topo_we), .i_waddr (topo_wa), .i_wdata (topo_wd),
        .i_re (topo_re), .i_raddr (topo_ra), .o_rdata (topo_q)
    );

    dlp_ram #(.WIDTH(DIST_W), .DEPTH(MAX_NODES)) u_best_ram (
        .i_clk (i_clk), .i_we (best_we), .i_waddr (best_wa), .i_wdata (best_wd),
        .i_re (best_re), .i_raddr (best_ra), .o_rdata (best_q)
    );

    always_comb begin
        if ($signed(best_q) > $signed(PATH_MAX)) begin
            path_sat = PATH_MAX;
        end else if ($signed(best_q) < $signed(PATH_MIN)) begin
            path_sat = PATH_MIN;
        end else begin
            path_sat = best_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CFG_RESET;
            r_cnt        <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            if (i_cfg_we) r_node_count <= i_cfg_data;
            if (r_ovalid && i_out_ready) r_ovalid <= 1'b0;
            case (i_op)
                OP_LOAD: if (load_ok) r_cnt <= r_cnt + CNTW'(1);
                OP_OUT, OP_FAIL_OUT: begin
                    r_cnt    <= '0;
                    r_ovalid <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_START: begin
                r_idx     <= '0;
                r_eidx    <= '0;
                r_head    <= '0;
                r_tail    <= '0;
                r_reached <= '0;
            end
            OP_CLR: r_idx <= idx_last ? '0 : r_idx + CW'(1);
            OP_EDGE_NEXT, OP_DEG_INC: r_eidx <= r_eidx + CNTW'(1);
            OP_SEED_CK: begin
                r_idx <= idx_last ? '0 : r_idx + CW'(1);
                if (deg_q == '0) r_tail <= r_tail + CW'(1);
            end
            OP_HEAD_RD: r_head <= r_head + CW'(1);
            OP_U_LATCH: begin
                r_u    <= topo_q;
                r_eidx <= '0;
            end
            OP_DEG_DEC: begin
                r_eidx <= r_eidx + CNTW'(1);
                if ((deg_dec == '0) && (r_tail < n_eff)) r_tail <= r_tail + CW'(1);
            end
            OP_ROOT_SET: begin
                r_reached[topo_q] <= 1'b1;
                r_idx             <= '0;
            end
            OP_TOPO_RD: r_idx <= r_idx + CW'(1);
            OP_U_BEST: begin
                r_u    <= topo_q;
                r_eidx <= '0;
            end
            OP_DU_LATCH: r_du <= best_q;
            OP_RELAX: begin
                r_eidx <= r_eidx + CNTW'(1);
                if (best_we) r_reached[e_dst_n] <= 1'b1;
            end
            OP_LAST_BEST: r_last_reached <= r_reached[topo_q];
            OP_OUT: begin
                r_path    <= r_last_reached ? PATH_W'(path_sat) : '0;
                r_unreach <= !r_last_reached;
                r_cycle   <= r_tail < n_eff;
            end
            OP_FAIL_OUT: begin
                r_path    <= '0;
                r_unreach <= 1'b1;
                r_cycle   <= 1'b1;
            end
            default: ;
        endcase
    end

    assign o_out_valid   = r_ovalid;
    assign o_path_length = r_path;
    assign o_unreachable = r_unreach;
    assign o_cycle_found = r_cycle;

`ifndef NO_ASSERTIONS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_cnt) <= MAX_EDGES)
        else $error("edge count beyond store depth");
    a_head_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == OP_HEAD_RD |-> r_head < r_tail)
        else $error("queue read past its tail");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_op == OP_DEG_DEC |-> deg_q != '0)
        else $error("in-degree underflow");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_op == OP_OUT || i_op == OP_FAIL_OUT) |=> r_cnt == '0 && r_ovalid)
        else $error("edge store not cleared after result");
`endif
endmodule

// ===== sv/dag_longest_path_unit.sv =====
// Edge word: accepted back to back while idle; no result.
// Compute word: the one-read-a-cycle edge store is walked once per ordered node in sort and
// once per reached ordered node in relax, for n nodes and E stored edges.
// Input is stalled during a compute; the result waits in an output register.
// Synchronous active-low reset empties the edge store, drops any pending result and
// sets node_count to 64; the node stores are rebuilt by every compute.
module dag_longest_path_unit #(
    parameter int MAX_NODES = 64,
    parameter int MAX_EDGES = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    dlp_in_if.sink                      i_in,
    dlp_out_if.source                   o_out,
    input  logic                        i_cfg_we,
    input  logic [dlp_pkg::CFG_W-1:0]   i_cfg_data
);
    import dlp_pkg::*;

    t_op   op;
    t_stat stat;

    dlp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_stat     (stat),
        .o_op       (op),
        .o_in_ready (i_in.ready)
    );

    dlp_dpath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in.valid),
        .i_in_mode     (i_in.mode),
        .i_src_node    (i_in.src_node),
        .i_dst_node    (i_in.dst_node),
        .i_edge_weight (i_in.edge_weight),
        .i_op          (op),
        .o_stat        (stat),
        .i_out_ready   (o_out.ready),
        .o_out_valid   (o_out.valid),
        .o_path_length (o_out.path_length),
        .o_unreachable (o_out.unreachable),
        .o_cycle_found (o_out.cycle_found)
    );
endmodule

// ===== tb/dlp_checker.sv =====
`timescale 1ns / 100ps

module dlp_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    dlp_in_if                          in_mon,
    dlp_out_if                         out_mon,
    input  logic                       i_cfg_we,
    input  logic [dlp_pkg::CFG_W-1:0]  i_cfg_data,
    output int                         o_errors,
    output int                         o_pending,
    output int                         o_results
);
    import dlp_pkg::*;

    localparam int N_MAX = 64;
    localparam int E_MAX = 256;

    typedef struct {
        logic signed [PATH_W-1:0] path_length;
        logic                     unreachable;
        logic                     cycle_found;
    } t_path_result;

    logic [NODE_W-1:0]          store_src [E_MAX];
    logic [NODE_W-1:0]          store_dst [E_MAX];
    logic signed [WEIGHT_W-1:0] store_cost[E_MAX];
    int                         store_fill;
    logic [CFG_W-1:0]           nodes_reg;
    t_path_result               path_queue[$];

    function automatic int nodes_live(logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > N_MAX) return N_MAX;
        return int'(v);
    endfunction

    // Kahn ordering followed by max relaxation over the stored edges.
    task automatic solve_longest_path();
        int           n;
        int           deg[N_MAX];
        int           order[N_MAX];
        longint       best_len[N_MAX];
        bit           seen[N_MAX];
        int           head;
        int           tail;
        int           u;
        int           v;
        longint       cand;
        longint       d;
        t_path_result r;
        n = nodes_live(nodes_reg);
        for (int i = 0; i < N_MAX; i++) begin
            deg[i] = 0;
            best_len[i] = 0;
            seen[i] = 0;
        end
        for (int e = 0; e < store_fill; e++)
            if (store_src[e] < n && store_dst[e] < n) deg[store_dst[e]]++;
        tail = 0;
        for (int i = 0; i < n; i++)
            if (deg[i] == 0) begin
                order[tail] = i;
                tail++;
            end
        head = 0;
        while (head < tail) begin
            u = order[head];
            head++;
            for (int e = 0; e < store_fill; e++) begin
                if (store_src[e] < n && store_dst[e] < n && store_src[e] == u) begin
                    v = int'(store_dst[e]);
                    deg[v]--;
                    if (deg[v] == 0 && tail < n) begin
                        order[tail] = v;
                        tail++;
                    end
                end
            end
        end
        if (tail == 0) begin
            r.path_length = '0;
            r.unreachable = 1'b1;
            r.cycle_found = 1'b1;
        end else begin
            seen[order[0]] = 1;
            for (int i = 0; i < tail; i++) begin
                u = order[i];
                if (seen[u]) begin
                    for (int e = 0; e < store_fill; e++) begin
                        if (store_src[e] < n && store_dst[e] < n && store_src[e] == u) begin
                            v = int'(store_dst[e]);
                            cand = best_len[u] + longint'(store_cost[e]);
                            if (!seen[v] || cand > best_len[v]) begin
                                best_len[v] = cand;
                                seen[v] = 1;
                            end
                        end
                    end
                end
            end
            u = order[tail-1];
            d = seen[u] ? best_len[u] : 0;
            if (d > 2097151) d = 2097151;
            if (d < -2097152) d = -2097152;
            r.path_length = d[PATH_W-1:0];
            r.unreachable = !seen[u];
            r.cycle_found = (tail < n);
        end
        path_queue = {path_queue, r};
        store_fill = 0;
    endtask

    always @(posedge i_clk) begin
        t_path_result x;
        int           n;
        if (!i_rst_n) begin
            store_fill = 0;
            nodes_reg = CFG_RESET;
            path_queue.delete();
            o_results = 0;
        end else begin
            if (i_cfg_we) nodes_reg = i_cfg_data;
            if (in_mon.valid && in_mon.ready) begin
                if (in_mon.mode) begin
                    solve_longest_path();
                end else begin
                    n = nodes_live(nodes_reg);
                    if (in_mon.src_node < n && in_mon.dst_node < n && store_fill < E_MAX) begin
                        store_src[store_fill] = in_mon.src_node;
                        store_dst[store_fill] = in_mon.dst_node;
                        store_cost[store_fill] = in_mon.edge_weight;
                        store_fill++;
                    end
                end
            end
            if (out_mon.valid && out_mon.ready) begin
                o_results++;
                if (path_queue.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result word: path %0d unr %0b cyc %0b",
                             $time, out_mon.path_length, out_mon.unreachable,
                             out_mon.cycle_found);
                end else begin
                    x = path_queue.pop_front();
                    if (out_mon.path_length !== x.path_length) begin
                        o_errors++;
                        $display("%0t: path_length expected %0d actual %0d",
                                 $time, x.path_length, out_mon.path_length);
                    end
                    if (out_mon.unreachable !== x.unreachable) begin
                        o_errors++;
                        $display("%0t: unreachable expected %0b actual %0b",
                                 $time, x.unreachable, out_mon.unreachable);
                    end
                    if (out_mon.cycle_found !== x.cycle_found) begin
                        o_errors++;
                        $display("%0t: cycle_found expected %0b actual %0b",
                                 $time, x.cycle_found, out_mon.cycle_found);
                    end
                end
            end
        end
        o_pending = path_queue.size();
    end

endmodule

// ===== tb/tb_dag_longest_path_unit.sv =====
`timescale 1ns / 100ps

module tb_dag_longest_path_unit;
    import dlp_pkg::*;

    localparam int WATCHDOG_LIMIT = 600000;
    localparam int SETTLE_CYCLES  = 40;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_data;
    int               errors;
    int               pending;
    int               results;
    int               send_idle_pct;
    int               recv_stall_pct;
    int               words_sent;
    int               computes_sent;
    int               quiet_cycles;

    dlp_in_if  in_ch ();
    dlp_out_if out_ch ();

    dag_longest_path_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_ch),
        .o_out      (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data)
    );

    dlp_checker i_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .in_mon     (in_ch),
        .out_mon    (out_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (cfg_data),
        .o_errors   (errors),
        .o_pending  (pending),
        .o_results  (results)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    always @(negedge i_clk) begin
        out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // Nothing accepted on either side for too long means the block hung.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired", $time);
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_word(logic mode, int s, int d, logic signed [WEIGHT_W-1:0] w);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.mode = mode;
        in_ch.src_node = NODE_W'(s);
        in_ch.dst_node = NODE_W'(d);
        in_ch.edge_weight = w;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        words_sent++;
        if (mode) computes_sent++;
    endtask

    task automatic compute_word();
        send_word(1'b1, int'($urandom_range(63)), int'($urandom_range(63)),
                  WEIGHT_W'($urandom));
    endtask

    // Only touch the register once the block has drained and gone quiet.
    task automatic set_nodes(int v);
        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        cfg_we = 1'b1;
        cfg_data = CFG_W'(v);
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic signed [WEIGHT_W-1:0] pick_weight();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 16'sh7fff;
        if (r < 10) return 16'sh8000;
        if (r < 40) return WEIGHT_W'($signed($urandom_range(40)) - 20);
        return WEIGHT_W'($urandom);
    endfunction

    // One graph: mostly forward edges (acyclic), some back edges and noise.
    task automatic random_graph(int max_edges);
        int               v;
        int               n;
        int               ne;
        int               r;
        int               a;
        int               b;
        r = $urandom_range(99);
        if (r < 70) v = int'($urandom_range(8, 1));
        else if (r < 90) v = int'($urandom_range(20, 9));
        else if (r < 95) v = 0;
        else if (r < 97) v = int'($urandom_range(127, 64));
        else v = int'($urandom_range(63, 21));
        set_nodes(v);
        n = (v == 0) ? 1 : (v > 64) ? 64 : v;
        ne = $urandom_range((n > 8) ? 30 : 3 * n, 0);
        if (ne > max_edges) ne = max_edges;
        for (int i = 0; i < ne; i++) begin
            r = $urandom_range(99);
            a = $urandom_range(n - 1);
            b = $urandom_range(n - 1);
            if (r < 80) begin
                if (a > b) send_word(1'b0, b, a, pick_weight());
                else if (a < b) send_word(1'b0, a, b, pick_weight());
                else if (n > 1 && a < n - 1) send_word(1'b0, a, a + 1, pick_weight());
                else send_word(1'b0, 0, a, pick_weight());
            end else if (r < 88) begin
                send_word(1'b0, a, b, pick_weight());
            end else begin
                send_word(1'b0, int'($urandom_range(63)), int'($urandom_range(63)),
                          pick_weight());
            end
        end
        compute_word();
    endtask

    initial begin
        int phase_goal;
        i_rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.mode = 1'b0;
        in_ch.src_node = '0;
        in_ch.dst_node = '0;
        in_ch.edge_weight = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        words_sent = 0;
        computes_sent = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Empty store at the reset node count: only node 0 is reached.
        compute_word();
        send_word(1'b0, 0, 1, 16'sh7fff);
        send_word(1'b0, 1, 63, 16'sh8000);
        send_word(1'b0, 0, 63, 16'sh8000);
        compute_word();
        // Zero nodes acts as one node.
        set_nodes(0);
        send_word(1'b0, 0, 0, 16'sh0001);
        compute_word();
        set_nodes(1);
        compute_word();
        // Two nodes in a loop leave nothing to order; out-of-range edges are dropped.
        set_nodes(2);
        send_word(1'b0, 0, 1, -16'sd5);
        send_word(1'b0, 1, 0, 16'sd7);
        send_word(1'b0, 5, 1, 16'sd9);
        send_word(1'b0, 0, 63, 16'sd9);
        compute_word();
        // Edges stored under a wide setting go stale after it shrinks.
        set_nodes(127);
        send_word(1'b0, 10, 11, 16'sd3);
        send_word(1'b0, 0, 2, 16'sd4);
        send_word(1'b0, 2, 3, -16'sd1);
        set_nodes(4);
        compute_word();
        // Partial order when a loop sits behind a good prefix.
        set_nodes(3);
        send_word(1'b0, 0, 1, 16'sd2);
        send_word(1'b0, 1, 2, 16'sd2);
        send_word(1'b0, 2, 1, 16'sd2);
        compute_word();

        // Long heavy chains exercise the distance width; the last overfills the store.
        set_nodes(64);
        for (int i = 0; i < 63; i++) send_word(1'b0, i, i + 1, 16'sh7fff);
        compute_word();
        for (int i = 0; i < 63; i++) send_word(1'b0, i, i + 1, 16'sh8000);
        for (int i = 0; i < 200; i++) send_word(1'b0, 0, 62, pick_weight());
        compute_word();

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            phase_goal = words_sent + 330;
            while (words_sent < phase_goal) random_graph(40);
        end

        in_ch.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        $display("Covered %0d input words, %0d of them computes, %0d results checked.",
                 words_sent, computes_sent, results);
        $display("Node counts from 0 to 127, four handshake pressure phases.");
        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
